/* rtl/sha1_pkg.sv */
// shared types, constants and helper functions for the sha-1 byte stream hasher
package sha1_pkg;

   // request opcodes carried on req_tuser
   localparam logic [1:0] OP_ABSORB  = 2'd0;
   localparam logic [1:0] OP_FINISH  = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   localparam int unsigned ROUNDS     = 80;
   localparam logic [4:0]  HASH_BYTES = 5'd20;
   localparam logic [7:0]  PAD_MARK   = 8'h80;
   localparam logic [5:0]  LAST_POS   = 6'd63;
   localparam logic [5:0]  ZERO_A_END = 6'd56;
   localparam logic [5:0]  LEN_POS    = 6'd60;

   // standard initial chaining words
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hc3d2e1f0;

   // round constants
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_FOLD  = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      PH_MARK  = 4'b0001,
      PH_ZERO1 = 4'b0010,
      PH_ZERO2 = 4'b0100,
      PH_LEN   = 4'b1000
   } pad_phase_type;

   // round constant for a given round number
   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) begin
         k = K0;
      end else if (r < 7'd40) begin
         k = K1;
      end else if (r < 7'd60) begin
         k = K2;
      end else begin
         k = K3;
      end
      return k;
   endfunction

   // boolean mix function for a given round number
   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

/* rtl/sha1_byte_stream_hasher.sv */
// sha-1 hasher fed one byte per request transfer, with digest readout
//
// Requests arrive on req_* : req_tuser carries the opcode (absorb, finish, read,
// restart) and req_tdata the message byte. Digest bytes leave on rsp_*, most
// significant byte of the first chaining word first, rsp_tlast on the final one.
// csr_wr_en/csr_wr_data set the digest read length (values above 20 read 20);
// write it only while the hasher is idle.
// An absorb shifts the byte into the block; every 64th byte then runs the
// compression (80 rounds on one shared round unit, then a fold of the result
// into the chaining value) before the next request is taken.
// A finish feeds 9 to 72 pad bytes through the same absorb path, one per
// cycle, pausing between pad phases and while each block it completes is
// compressed and folded. A read produces one byte per cycle for as long as
// rsp_tready is high; a stall holds the current byte and freezes the hasher.
// req_tready is low whenever a request is being worked on.
// Reset loads the standard initial chaining value, clears byte position and
// block count, and sets the read length to 20.
module sha1_byte_stream_hasher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] digest_byte
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   sha1_pkg::state_type     state_ff, state_in;
   sha1_pkg::pad_phase_type phase_ff, phase_in;

   logic [31:0]  cv_ff [5];
   logic [31:0]  cv_in [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [511:0] blk_ff, blk_in;
   logic [5:0]   pos_ff, pos_in;
   logic [22:0]  count_ff, count_in;
   logic [6:0]   round_ff, round_in;
   logic [4:0]   dlen_ff, dlen_in;
   logic [4:0]   rd_len_ff, rd_len_in;
   logic [4:0]   rd_idx_ff, rd_idx_in;
   logic [31:0]  bits_ff, bits_in;
   logic [1:0]   len_idx_ff, len_idx_in;
   logic         pad_active_ff, pad_active_in;

   logic         req_fire;
   logic         rsp_fire;
   logic         absorb_en;
   logic [7:0]   absorb_byte;
   logic [4:0]   rd_count;
   logic [31:0]  w0, w2, w8, w13, sched_x, sched_new;
   logic [31:0]  round_t;
   logic [31:0]  rd_word;

   assign req_tready = (state_ff == sha1_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == sha1_pkg::ST_READ);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tlast  = (rd_idx_ff + 5'd1 == rd_len_ff);

   // read length clamp
   assign rd_count = (dlen_ff > sha1_pkg::HASH_BYTES) ? sha1_pkg::HASH_BYTES : dlen_ff;

   // message schedule taps on the block shift line
   assign w0        = blk_ff[511:480];
   assign w2        = blk_ff[447:416];
   assign w8        = blk_ff[255:224];
   assign w13       = blk_ff[95:64];
   assign sched_x   = w13 ^ w8 ^ w2 ^ w0;
   assign sched_new = {sched_x[30:0], sched_x[31]};

   // shared round unit
   assign round_t = sha1_pkg::round_f(round_ff, b_ff, c_ff, d_ff)
                  + sha1_pkg::round_k(round_ff)
                  + {a_ff[26:0], a_ff[31:27]} + e_ff + w0;

   // digest byte select
   assign rd_word = cv_ff[rd_idx_ff[4:2]];
   always_comb begin
      case (rd_idx_ff[1:0])
         2'd0:    rsp_tdata = rd_word[31:24];
         2'd1:    rsp_tdata = rd_word[23:16];
         2'd2:    rsp_tdata = rd_word[15:8];
         default: rsp_tdata = rd_word[7:0];
      endcase
   end

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cv_in         = cv_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      blk_in        = blk_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      round_in      = round_ff;
      dlen_in       = csr_wr_en ? csr_wr_data : dlen_ff;
      rd_len_in     = rd_len_ff;
      rd_idx_in     = rd_idx_ff;
      bits_in       = bits_ff;
      len_idx_in    = len_idx_ff;
      pad_active_in = pad_active_ff;
      absorb_en     = 1'b0;
      absorb_byte   = 8'h00;

      case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  sha1_pkg::OP_ABSORB: begin
                     absorb_en   = 1'b1;
                     absorb_byte = req_tdata;
                  end
                  sha1_pkg::OP_FINISH: begin
                     bits_in       = {count_ff, pos_ff, 3'b000};
                     pad_active_in = 1'b1;
                     phase_in      = sha1_pkg::PH_MARK;
                     state_in      = sha1_pkg::ST_PAD;
                  end
                  sha1_pkg::OP_READ: begin
                     rd_len_in = rd_count;
                     rd_idx_in = 5'd0;
                     if (rd_count != 5'd0) begin
                        state_in = sha1_pkg::ST_READ;
                     end
                  end
                  default: begin
                     cv_in[0] = sha1_pkg::IV0;
                     cv_in[1] = sha1_pkg::IV1;
                     cv_in[2] = sha1_pkg::IV2;
                     cv_in[3] = sha1_pkg::IV3;
                     cv_in[4] = sha1_pkg::IV4;
                     pos_in   = 6'd0;
                     count_in = 23'd0;
                  end
               endcase
            end
         end
         sha1_pkg::ST_PAD: begin
            case (phase_ff)
               sha1_pkg::PH_MARK: begin
                  absorb_en   = 1'b1;
                  absorb_byte = sha1_pkg::PAD_MARK;
                  phase_in    = sha1_pkg::PH_ZERO1;
               end
               sha1_pkg::PH_ZERO1: begin
                  if (pos_ff > sha1_pkg::ZERO_A_END) begin
                     absorb_en = 1'b1;
                  end else begin
                     phase_in = sha1_pkg::PH_ZERO2;
                  end
               end
               sha1_pkg::PH_ZERO2: begin
                  if (pos_ff < sha1_pkg::LEN_POS) begin
                     absorb_en = 1'b1;
                  end else begin
                     phase_in   = sha1_pkg::PH_LEN;
                     len_idx_in = 2'd0;
                  end
               end
               default: begin
                  absorb_en = 1'b1;
                  case (len_idx_ff)
                     2'd0:    absorb_byte = bits_ff[31:24];
                     2'd1:    absorb_byte = bits_ff[23:16];
                     2'd2:    absorb_byte = bits_ff[15:8];
                     default: absorb_byte = bits_ff[7:0];
                  endcase
                  len_idx_in = len_idx_ff + 2'd1;
                  // the last length byte always completes a block
                  if (len_idx_ff == 2'd3) begin
                     pad_active_in = 1'b0;
                  end
               end
            endcase
         end
         sha1_pkg::ST_ROUND: begin
            a_in     = round_t;
            b_in     = a_ff;
            c_in     = {b_ff[1:0], b_ff[31:2]};
            d_in     = c_ff;
            e_in     = d_ff;
            blk_in   = {blk_ff[479:0], sched_new};
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(sha1_pkg::ROUNDS - 1)) begin
               state_in = sha1_pkg::ST_FOLD;
            end
         end
         sha1_pkg::ST_FOLD: begin
            cv_in[0] = cv_ff[0] + a_ff;
            cv_in[1] = cv_ff[1] + b_ff;
            cv_in[2] = cv_ff[2] + c_ff;
            cv_in[3] = cv_ff[3] + d_ff;
            cv_in[4] = cv_ff[4] + e_ff;
            count_in = count_ff + 23'd1;
            state_in = pad_active_ff ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
         end
         sha1_pkg::ST_READ: begin
            if (rsp_fire) begin
               rd_idx_in = rd_idx_ff + 5'd1;
               if (rsp_tlast) begin
                  state_in = sha1_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1_pkg::ST_IDLE;
         end
      endcase

      // shared byte absorb path, starts compression on a full block
      if (absorb_en) begin
         blk_in = {blk_ff[503:0], absorb_byte};
         pos_in = pos_ff + 6'd1;
         if (pos_ff == sha1_pkg::LAST_POS) begin
            a_in     = cv_ff[0];
            b_in     = cv_ff[1];
            c_in     = cv_ff[2];
            d_in     = cv_ff[3];
            e_in     = cv_ff[4];
            round_in = 7'd0;
            state_in = sha1_pkg::ST_ROUND;
         end
      end
   end

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sha1_pkg::ST_IDLE;
         phase_ff      <= sha1_pkg::PH_MARK;
         cv_ff[0]      <= sha1_pkg::IV0;
         cv_ff[1]      <= sha1_pkg::IV1;
         cv_ff[2]      <= sha1_pkg::IV2;
         cv_ff[3]      <= sha1_pkg::IV3;
         cv_ff[4]      <= sha1_pkg::IV4;
         pos_ff        <= 6'd0;
         count_ff      <= 23'd0;
         round_ff      <= 7'd0;
         dlen_ff       <= sha1_pkg::HASH_BYTES;
         rd_len_ff     <= 5'd0;
         rd_idx_ff     <= 5'd0;
         len_idx_ff    <= 2'd0;
         pad_active_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         cv_ff         <= cv_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         round_ff      <= round_in;
         dlen_ff       <= dlen_in;
         rd_len_ff     <= rd_len_in;
         rd_idx_ff     <= rd_idx_in;
         len_idx_ff    <= len_idx_in;
         pad_active_ff <= pad_active_in;
      end
   end

   // working variables, block shift line and length latch
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      blk_ff  <= blk_in;
      bits_ff <= bits_in;
   end

   // no request taken while digest bytes are outstanding
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("request accepted during digest readout");

   // round counter stays inside the round range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1_pkg::ST_ROUND) |-> (round_ff < 7'(sha1_pkg::ROUNDS)))
      else $error("round counter out of range");

   // the final digest transfer returns the hasher to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> req_tready)
      else $error("hasher not idle after last digest byte");

   // padding never left pending while idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1_pkg::ST_IDLE) |-> !pad_active_ff)
      else $error("padding pending while idle");

   // a fold always follows the last round and only it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1_pkg::ST_FOLD) |-> ($past(state_ff) == sha1_pkg::ST_ROUND))
      else $error("fold without preceding round");

endmodule
